FILE: rtl/lfd_pkg.sv
// ---------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the lidar frame decoder
// Frame layout constants, controller state encoding and the command and
// status bundles passed between controller and datapath.
// ---------------------------------------------------------------------------
package lfd_pkg;

  // Frame layout
  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] HDR_LAST     = 8'd3;
  localparam logic [7:0] CSUM_FIRST   = 8'd4;
  localparam logic [7:0] CMD_POS      = 8'd5;
  localparam logic [7:0] REC_FIRST    = 8'd10;
  localparam logic [7:0] REC_END      = 8'd190;
  localparam logic [7:0] FRAME_LAST   = 8'd194;
  localparam logic [3:0] REC_LAST_OFF = 4'd14;
  localparam logic [3:0] PT_LAST      = 4'd11;

  localparam int POINTS    = 12;
  localparam int REC_BYTES = 15;
  localparam int REC_STAGE = REC_BYTES - 1;
  localparam int REC_W     = 8 * REC_BYTES;

  // Defaults
  localparam int         DEF_CHANNELS = 4;
  localparam logic [7:0] CMD_RESET    = 8'd2;

  // floor(x / 3) for x below 2**23 is (x * AVG_RECIP) >> AVG_SHIFT
  localparam int          AVG_SHIFT = 23;
  localparam logic [21:0] AVG_RECIP = 22'd2796203;

  localparam int SUM_W        = 20;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TUSER_W  = 2;
  localparam int OUT_TDATA_W  = 4 + REC_W + SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_WAIT
  } lfd_state_t;

  typedef struct packed {
    logic take;   // input byte transfer this cycle
    logic rd;     // read the point record and refresh the average
    logic load;   // move read data into the output register
  } lfd_cmd_t;

  typedef struct packed {
    logic frame_done;  // accepted byte closed a good frame
    logic last_pt;     // point counter sits on the final point
    logic out_busy;    // output register holds a result
    logic out_fire;    // result transfer this cycle
  } lfd_stat_t;

endpackage

FILE: rtl/lfd_ram.sv
// ---------------------------------------------------------------------------
// lfd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lfd_ctrl.sv
// ---------------------------------------------------------------------------
// lfd_ctrl: frame decoder controller
// Takes bytes while idle, then walks the twelve point reads of a good frame
// through the output register.
// ---------------------------------------------------------------------------
module lfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  lfd_pkg::lfd_stat_t stat,
  output lfd_pkg::lfd_cmd_t  cmd
);
  import lfd_pkg::*;

  lfd_state_t state_r;
  lfd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stat.frame_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = stat.last_pt ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.out_fire) begin
          state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // a pending final result leaves the register in this same cycle
        in_tready = !stat.out_busy || out_tready;
        cmd.take  = in_tvalid && in_tready;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_WAIT: begin
        cmd = '0;
      end
      default: cmd = '0;
    endcase
  end

  a_done_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    stat.frame_done |=> state_r == ST_RD)
    else $error("good frame did not start the point reads");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && stat.last_pt) |=> state_r == ST_IDLE)
    else $error("final point load did not return to idle");

  a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> stat.out_busy)
    else $error("output register empty after a load");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.frame_done |-> (state_r == ST_IDLE && cmd.take))
    else $error("frame completed outside a byte transfer");

endmodule

FILE: rtl/lfd_dpath.sv
// ---------------------------------------------------------------------------
// lfd_dpath: frame decoder datapath
// Per-channel parse state, record staging, point RAM, average and the
// output register.
// ---------------------------------------------------------------------------
module lfd_dpath #(
  parameter int CHANNELS = lfd_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lfd_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic [7:0]                      in_tdata,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata,
  input  lfd_pkg::lfd_cmd_t               cmd,
  output lfd_pkg::lfd_stat_t              stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lfd_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import lfd_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * POINTS;
  localparam int ADDR_W = $clog2(DEPTH);

  // per-channel parse state
  logic [7:0]       pos_r   [CHANNELS];
  logic [7:0]       csum_r  [CHANNELS];
  logic             live_r  [CHANNELS];
  logic [SUM_W-1:0] dsum_r  [CHANNELS];
  logic [3:0]       off_r   [CHANNELS];
  logic [3:0]       idx_r   [CHANNELS];
  logic [7:0]       stage_r [CHANNELS][REC_STAGE];

  logic [7:0]       cmd_code_r;

  logic [1:0]       ch_in;
  logic [CH_W-1:0]  ch_idx;
  logic             start;
  logic [7:0]       rx_byte;
  logic             in_range;
  logic             active;

  logic [7:0]       cur_pos;
  logic [7:0]       cur_csum;
  logic [SUM_W-1:0] cur_dsum;
  logic [3:0]       cur_off;
  logic [3:0]       cur_idx;

  logic [7:0]       pos_nxt;
  logic [7:0]       csum_nxt;
  logic             live_nxt;
  logic [SUM_W-1:0] dsum_nxt;
  logic [3:0]       off_nxt;
  logic [3:0]       idx_nxt;

  logic             hdr_bad;
  logic             cmd_bad;
  logic             at_end;
  logic             in_rec;
  logic             stage_we;
  logic             ram_we;
  logic             frame_done;
  logic [ADDR_W-1:0] wr_addr;
  logic [REC_W-1:0] rec_word;
  logic [REC_W-1:0] ram_rdata;

  // emission
  logic [CH_W-1:0]  emit_ch_r;
  logic [SUM_W-1:0] emit_sum_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [3:0]       pt_r;
  logic [SUM_W-1:0] avg_r;
  logic [43:0]      avg_prod;

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_ch_r;
  logic                   out_last_r;
  logic                   out_valid_r;
  logic                   out_fire;

  assign ch_in    = in_tuser[1:0];
  assign start    = in_tuser[2];
  assign rx_byte  = in_tdata;
  assign ch_idx   = CH_W'(ch_in);
  assign in_range = int'(ch_in) < CHANNELS;

  always_comb begin
    cur_pos  = start ? '0 : pos_r[ch_idx];
    cur_csum = start ? '0 : csum_r[ch_idx];
    cur_dsum = start ? '0 : dsum_r[ch_idx];
    cur_off  = start ? '0 : off_r[ch_idx];
    cur_idx  = start ? '0 : idx_r[ch_idx];
    active   = cmd.take && in_range && (start || live_r[ch_idx]);

    hdr_bad = (cur_pos <= HDR_LAST) && (rx_byte != SYNC_BYTE);
    cmd_bad = (cur_pos == CMD_POS) && (rx_byte != cmd_code_r);
    at_end  = cur_pos == FRAME_LAST;
    in_rec  = (cur_pos >= REC_FIRST) && (cur_pos < REC_END);

    pos_nxt    = cur_pos + 8'd1;
    csum_nxt   = (cur_pos >= CSUM_FIRST) ? cur_csum + rx_byte : cur_csum;
    live_nxt   = 1'b1;
    dsum_nxt   = cur_dsum;
    off_nxt    = cur_off;
    idx_nxt    = cur_idx;
    stage_we   = 1'b0;
    ram_we     = 1'b0;
    frame_done = 1'b0;

    if (hdr_bad || cmd_bad) begin
      live_nxt = 1'b0;
    end else if (at_end) begin
      live_nxt   = 1'b0;
      frame_done = active && (rx_byte == cur_csum);
    end else if (in_rec) begin
      if (cur_off == REC_LAST_OFF) begin
        // last byte of a record: write the whole record
        ram_we  = active;
        off_nxt = '0;
        idx_nxt = cur_idx + 4'd1;
      end else begin
        stage_we = active;
        off_nxt  = cur_off + 4'd1;
      end
      if (cur_off == 4'd0) begin
        dsum_nxt = cur_dsum + SUM_W'(rx_byte);
      end else if (cur_off == 4'd1) begin
        dsum_nxt = cur_dsum + SUM_W'({rx_byte, 8'd0});
      end
    end
  end

  always_comb begin
    for (int k = 0; k < REC_STAGE; k++) begin
      rec_word[8*k +: 8] = stage_r[ch_idx][k];
    end
    rec_word[REC_W-1 -: 8] = rx_byte;
  end

  assign wr_addr = ADDR_W'(int'(ch_idx) * POINTS + int'(cur_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        live_r[c] <= 1'b0;
      end
    end else if (active) begin
      live_r[ch_idx] <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      pos_r[ch_idx]  <= pos_nxt;
      csum_r[ch_idx] <= csum_nxt;
      dsum_r[ch_idx] <= dsum_nxt;
      off_r[ch_idx]  <= off_nxt;
      idx_r[ch_idx]  <= idx_nxt;
    end
    if (stage_we) begin
      stage_r[ch_idx][cur_off] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_code_r <= CMD_RESET;
    end else if (cfg_we) begin
      cmd_code_r <= cfg_wdata;
    end
  end

  lfd_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_point_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (rec_word),
    .re    (cmd.rd),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // sum * 16 / 12 = (sum * 4) / 3
  assign avg_prod = 44'({emit_sum_r, 2'b00}) * 44'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (frame_done) begin
      emit_ch_r  <= ch_idx;
      emit_sum_r <= cur_dsum;
      rd_addr_r  <= ADDR_W'(int'(ch_idx) * POINTS);
      pt_r       <= '0;
    end else if (cmd.load) begin
      rd_addr_r <= rd_addr_r + ADDR_W'(1);
      pt_r      <= pt_r + 4'd1;
    end
    if (cmd.rd) begin
      avg_r <= avg_prod[AVG_SHIFT + SUM_W - 1 : AVG_SHIFT];
    end
    if (cmd.load) begin
      out_data_r <= {avg_r, ram_rdata, pt_r};
      out_ch_r   <= OUT_TUSER_W'(emit_ch_r);
      out_last_r <= pt_r == PT_LAST;
    end
  end

  assign out_fire = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    stat.frame_done = frame_done;
    stat.last_pt    = pt_r == PT_LAST;
    stat.out_busy   = out_valid_r;
    stat.out_fire   = out_fire;
  end

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r)
    else $error("point loaded over a pending result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=>
      (out_valid_r && $stable(out_data_r) && $stable(out_ch_r) && $stable(out_last_r)))
    else $error("stalled result changed before its transfer");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && cmd.rd))
    else $error("point RAM written during an unload read");

endmodule

FILE: rtl/lidar_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// lidar_frame_decoder_top: per-channel lidar distance frame decoder
// Parses 195-byte frames on up to CHANNELS interleaved sensors and emits
// twelve decoded points with the frame's distance average per good frame.
//
//   port group  dir  tdata                       tuser
//   in_*        in   rx_byte                     channel, frame_start
//   out_*       out  point fields, see below     out_channel
//   cfg_*       in   command_code                -
//
// One byte per cycle is taken while no frame is being unloaded.
// The byte that closes a good frame starts the unload: each point is one
// read of the point RAM plus a load of the output register; the first read
// follows that byte, each further read follows the transfer of the previous
// result; input resumes once the final point is loaded. A stalled result
// holds the output register and closes the input.
// rst_n is synchronous; the point RAM is not cleared.
// ---------------------------------------------------------------------------
module lidar_frame_decoder_top #(
  parameter int CHANNELS = lfd_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  input  logic [lfd_pkg::IN_TUSER_W-1:0]  in_tuser,   // channel[1:0], frame_start[2]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // point_index[3:0], distance[19:4], noise[35:20], peak[67:36],
  // confidence[75:68], integration_time[107:76], reference_tof[123:108],
  // avg_distance_q4[143:124]
  output logic [lfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lfd_pkg::OUT_TUSER_W-1:0] out_tuser,  // out_channel
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata   // command_code
);
  import lfd_pkg::*;

  lfd_cmd_t  cmd;
  lfd_stat_t stat;

  lfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lfd_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
